// File: src/tdsm_pkg.sv
// Shared constants and elaboration-time helpers for the tank drive stick mixer.
// Holds register indexes, latency formulas and the exp2 step constant builder.
// No dependencies.
package tdsm_pkg;

    // Configuration register indexes (byte address / 4)
    localparam logic [2:0] REG_DEADZONE       = 3'd0;
    localparam logic [2:0] REG_CURVE_EXPONENT = 3'd1;
    localparam logic [2:0] REG_THROTTLE_LIMIT = 3'd2;
    localparam logic [2:0] REG_STEERING_LIMIT = 3'd3;
    localparam logic [2:0] REG_SLOW_FACTOR    = 3'd4;

    localparam int PADDR_W = 5;

    // Cycles from an accepted start to the shaped axis values
    function automatic int shaper_latency(int w, int s);
        return w + 2 * s + 5;
    endfunction

    // Cycles from an accepted start to the done strobe
    function automatic int core_latency(int w, int s);
        return shaper_latency(w, s) + 3;
    endfunction

    // Integer square root, used at elaboration only
    function automatic logic [63:0] isqrt64(logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bt;
        v   = v_in;
        res = '0;
        bt  = 64'd1 << 62;
        while (bt > v)
            bt = bt >> 2;
        while (bt != 0)
        begin
            if (v >= res + bt)
            begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end
            else
            begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // Step constant c_j ~ 2^(-2^-j) in Q1.31, c_0 = 0.5
    function automatic logic [31:0] exp_step_const(int j);
        logic [63:0] c;
        c = 64'd1 << 30;
        for (int i = 1; i <= j; i++)
            c = isqrt64(c << 31);
        return c[31:0];
    endfunction

endpackage

// File: src/tdsm_shaper.sv
// Per-axis shaping pipeline: deadzone divide, log2 by squaring, exp2 by
// constant products, and axis limit, for throttle and steering lanes.
// Depends on tdsm_pkg.
module tdsm_shaper #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int POW_STEPS    = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [SAMPLE_WIDTH-1:0]     throttle,
    input  logic [SAMPLE_WIDTH-1:0]     steering,
    input  logic                        slow_en,
    input  logic [SAMPLE_WIDTH-2:0]     deadzone,
    input  logic [SAMPLE_WIDTH-2:0]     curve_exponent,
    input  logic [SAMPLE_WIDTH-2:0]     throttle_limit,
    input  logic [SAMPLE_WIDTH-2:0]     steering_limit,
    output logic                        out_valid,
    output logic                        out_slow,
    output logic signed [SAMPLE_WIDTH:0] throttle_shaped,
    output logic signed [SAMPLE_WIDTH:0] steering_shaped
);
    import tdsm_pkg::*;

    localparam int W   = SAMPLE_WIDTH;
    localparam int F   = W - 1;
    localparam int S   = POW_STEPS;
    localparam int E   = F - 3;
    localparam int NHW = $clog2(F + 1);
    localparam int NW  = NHW + S;
    localparam int AW  = S + F;
    localparam int XW  = NHW + F;
    localparam int BW  = XW + 1;
    localparam int IPW = BW - E;
    localparam int LAT = shaper_latency(W, S);
    localparam logic [W-1:0] ONE_W = W'(1) << F;

    typedef struct packed {
        logic         neg;
        logic         byp;
        logic [W-1:0] sv;
    } side_t;

    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] slw_reg;
    logic [W-1:0]   divisor;
    logic [W-1:0]   raw [2];
    logic [F-1:0]   lim [2];

    logic [W-1:0]      dv_rem_reg  [2][W+1];
    logic [W-1:0]      dv_q_reg    [2][W+1];
    logic              dv_neg_reg  [2][W+1];
    logic              dv_lsb_reg  [2];
    logic [31:0]       sq_m_reg    [2][S+1];
    logic [S-1:0]      sq_f_reg    [2][S+1];
    logic [NHW-1:0]    sq_p_reg    [2][S+1];
    side_t             sq_side_reg [2][S+1];
    logic [AW-1:0]     mx_a_reg    [2];
    logic [XW-1:0]     mx_x_reg    [2];
    side_t             mx_side_reg [2];
    logic [31:0]       ex_r_reg    [2][S+1];
    logic [S-1:0]      ex_g_reg    [2][S+1];
    logic [4:0]        ex_sh_reg   [2][S+1];
    side_t             ex_side_reg [2][S+1];
    logic signed [W:0] out_reg     [2];

    assign raw[0]  = throttle;
    assign raw[1]  = steering;
    assign lim[0]  = throttle_limit;
    assign lim[1]  = steering_limit;
    assign divisor = ONE_W - {1'b0, deadzone};

    // Advance valid and slow flag alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        slw_reg <= {slw_reg[LAT-2:0], slow_en};
    end

    assign out_valid       = vld_reg[LAT-1];
    assign out_slow        = slw_reg[LAT-1];
    assign throttle_shaped = out_reg[0];
    assign steering_shaped = out_reg[1];

    genvar l, k;
    generate
        for (l = 0; l < 2; l++)
        begin : g_lane
            logic         neg_in;
            logic [W-1:0] mag;
            logic [W-1:0] num;
            logic [W-1:0] s_q;
            logic [NHW-1:0] lead;
            logic [31:0]  m0;
            logic         byp0;
            logic [NW-1:0] n_log;
            logic [BW-1:0] b_sum;
            logic [IPW-1:0] ip;
            logic [E+S-1:0] g_cat;
            logic         ip_zero;
            logic [31:0]  r_sh;
            logic [W-1:0] t_val;
            logic [W-1:0] t_lim;

            // Take magnitude and remove deadzone
            assign neg_in = raw[l][F];
            assign mag    = neg_in ? (~raw[l] + W'(1)) : raw[l];
            assign num    = (mag >= {1'b0, deadzone}) ? (mag - {1'b0, deadzone}) : '0;

            always_ff @(posedge clk)
            begin
                dv_rem_reg[l][0] <= num >> 1;
                dv_lsb_reg[l]    <= num[0];
                dv_q_reg[l][0]   <= '0;
                dv_neg_reg[l][0] <= neg_in;
            end

            // Restoring divide, one quotient bit per stage
            for (k = 0; k < W; k++)
            begin : g_div
                logic [W:0] trial;
                logic [W:0] diff;
                logic       take;
                assign trial = {dv_rem_reg[l][k], (k == 0) ? dv_lsb_reg[l] : 1'b0};
                assign diff  = trial - {1'b0, divisor};
                assign take  = trial >= {1'b0, divisor};
                always_ff @(posedge clk)
                begin
                    dv_rem_reg[l][k+1] <= take ? diff[W-1:0] : trial[W-1:0];
                    dv_q_reg[l][k+1]   <= {dv_q_reg[l][k][W-2:0], take};
                    dv_neg_reg[l][k+1] <= dv_neg_reg[l][k];
                end
            end

            // Normalize to a Q1.31 mantissa, flag the linear and end cases
            assign s_q = dv_q_reg[l][W];

            always_comb
            begin
                lead = '0;
                for (int i = 0; i < F; i++)
                    if (s_q[i])
                        lead = NHW'(i);
            end

            assign m0   = {s_q[F-1:0], {(32-F){1'b0}}} << (NHW'(F - 1) - lead);
            assign byp0 = (curve_exponent == '0) || (s_q == '0) || s_q[F];

            always_ff @(posedge clk)
            begin
                sq_m_reg[l][0]    <= m0;
                sq_f_reg[l][0]    <= '0;
                sq_p_reg[l][0]    <= lead;
                sq_side_reg[l][0] <= '{neg: dv_neg_reg[l][W], byp: byp0, sv: s_q};
            end

            // Square the mantissa, one log2 fraction bit per stage
            for (k = 0; k < S; k++)
            begin : g_sq
                logic [63:0] prod;
                logic [32:0] sq;
                assign prod = {32'b0, sq_m_reg[l][k]} * {32'b0, sq_m_reg[l][k]};
                assign sq   = prod[63:31];
                always_ff @(posedge clk)
                begin
                    sq_m_reg[l][k+1]    <= sq[32] ? sq[32:1] : sq[31:0];
                    sq_f_reg[l][k+1]    <= {sq_f_reg[l][k][S-2:0], sq[32]};
                    sq_p_reg[l][k+1]    <= sq_p_reg[l][k];
                    sq_side_reg[l][k+1] <= sq_side_reg[l][k];
                end
            end

            // Form -log2 and scale it by the exponent
            assign n_log = {NHW'(F) - sq_p_reg[l][S], {S{1'b0}}} - {{NHW{1'b0}}, sq_f_reg[l][S]};

            always_ff @(posedge clk)
            begin
                mx_a_reg[l]    <= AW'(n_log[S-1:0]) * AW'(curve_exponent);
                mx_x_reg[l]    <= XW'(n_log[NW-1:S]) * XW'(curve_exponent);
                mx_side_reg[l] <= sq_side_reg[l][S];
            end

            // Split the product into integer shift and fraction bits
            assign b_sum   = BW'(mx_x_reg[l]) + BW'(mx_a_reg[l] >> S);
            assign ip      = b_sum[BW-1:E];
            assign g_cat   = {b_sum[E-1:0], mx_a_reg[l][S-1:0]};
            assign ip_zero = ip > IPW'(F);

            always_ff @(posedge clk)
            begin
                ex_r_reg[l][0]    <= 32'd1 << 31;
                ex_g_reg[l][0]    <= g_cat[E+S-1:E];
                ex_sh_reg[l][0]   <= 5'(IPW'(31 - F) + ip);
                ex_side_reg[l][0] <= '{neg: mx_side_reg[l].neg,
                                       byp: mx_side_reg[l].byp | ip_zero,
                                       sv:  mx_side_reg[l].byp ? mx_side_reg[l].sv : '0};
            end

            // Build exp2 of the fraction, one constant product per stage
            for (k = 0; k < S; k++)
            begin : g_exp
                localparam logic [31:0] CJ = exp_step_const(k + 1);
                logic [63:0] prod;
                assign prod = {32'b0, ex_r_reg[l][k]} * {32'b0, CJ};
                always_ff @(posedge clk)
                begin
                    ex_r_reg[l][k+1]    <= ex_g_reg[l][k][S-1-k] ? prod[62:31] : ex_r_reg[l][k];
                    ex_g_reg[l][k+1]    <= ex_g_reg[l][k];
                    ex_sh_reg[l][k+1]   <= ex_sh_reg[l][k];
                    ex_side_reg[l][k+1] <= ex_side_reg[l][k];
                end
            end

            // Shift down, clamp to the axis limit, restore the sign
            assign r_sh  = ex_r_reg[l][S] >> ex_sh_reg[l][S];
            assign t_val = ex_side_reg[l][S].byp ? ex_side_reg[l][S].sv : r_sh[W-1:0];
            assign t_lim = (t_val > {1'b0, lim[l]}) ? {1'b0, lim[l]} : t_val;

            always_ff @(posedge clk)
            begin
                out_reg[l] <= ex_side_reg[l][S].neg ? -$signed({1'b0, t_lim})
                                                    : $signed({1'b0, t_lim});
            end
        end
    endgenerate

endmodule

// File: src/tank_drive_stick_mixer_core.sv
// Top level of the tank drive stick mixer: APB register file, shaping
// pipeline and left/right mixing with slow-mode scaling. Depends on tdsm_pkg
// and tdsm_shaper.
//
// A sample is taken on every cycle that start is high; busy never rises, so
// one sample per clock is sustained. The result appears on left_drive and
// right_drive with done high for one cycle, once the sample has passed the
// one-bit-per-stage deadzone divider, the POW_STEPS log2 squaring stages and
// the POW_STEPS exp2 product stages. Results cannot be held off: capture each
// one in the cycle done is high. Write registers only with no sample in
// flight.
module tank_drive_stick_mixer_core #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int POW_STEPS    = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tdsm_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [SAMPLE_WIDTH-1:0] throttle,
    input  logic signed [SAMPLE_WIDTH-1:0] steering,
    input  logic                           slow_en,
    output logic                           done,
    output logic signed [SAMPLE_WIDTH-1:0] left_drive,
    output logic signed [SAMPLE_WIDTH-1:0] right_drive
);
    import tdsm_pkg::*;

    localparam int W  = SAMPLE_WIDTH;
    localparam int F  = W - 1;
    localparam int RW = W - 1;
    localparam logic [RW-1:0] DZ_RST    = RW'((64'd1638 << F) >> 15);
    localparam logic [RW-1:0] EXP_RST   = RW'(1) << (F - 3);
    localparam logic [RW-1:0] LIM_RST   = '1;
    localparam logic [RW-1:0] SLOW_RST  = RW'(1) << (F - 1);
    localparam logic signed [W+1:0] POS_ONE = (W+2)'(1) << F;
    localparam logic signed [W+1:0] NEG_ONE = -((W+2)'(1) << F);
    localparam logic signed [W:0]   POS_MAX = ((W+1)'(1) << F) - (W+1)'(1);

    logic [RW-1:0] deadzone_reg;
    logic [RW-1:0] curve_exponent_reg;
    logic [RW-1:0] throttle_limit_reg;
    logic [RW-1:0] steering_limit_reg;
    logic [RW-1:0] slow_factor_reg;
    logic          wr_beat;
    logic [2:0]    reg_idx;

    logic                shp_valid;
    logic                shp_slow;
    logic signed [W:0]   thr_shaped;
    logic signed [W:0]   ste_shaped;

    logic signed [W+1:0] sum_l;
    logic signed [W+1:0] sum_r;
    logic signed [W:0]   mix_next [2];
    logic signed [W:0]   mix_reg  [2];
    logic                mix_vld_reg;
    logic                mix_slow_reg;
    logic signed [W:0]   scl_next [2];
    logic signed [W:0]   scl_reg  [2];
    logic                scl_vld_reg;
    logic [W-1:0]        out_next [2];
    logic [W-1:0]        out_reg  [2];
    logic                done_reg;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign wr_beat = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg       <= DZ_RST;
            curve_exponent_reg <= EXP_RST;
            throttle_limit_reg <= LIM_RST;
            steering_limit_reg <= LIM_RST;
            slow_factor_reg    <= SLOW_RST;
        end
        else if (wr_beat)
        begin
            case (reg_idx)
                REG_DEADZONE:       deadzone_reg       <= pwdata[RW-1:0];
                REG_CURVE_EXPONENT: curve_exponent_reg <= pwdata[RW-1:0];
                REG_THROTTLE_LIMIT: throttle_limit_reg <= pwdata[RW-1:0];
                REG_STEERING_LIMIT: steering_limit_reg <= pwdata[RW-1:0];
                REG_SLOW_FACTOR:    slow_factor_reg    <= pwdata[RW-1:0];
                default:            ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (reg_idx)
            REG_DEADZONE:       prdata = 32'(deadzone_reg);
            REG_CURVE_EXPONENT: prdata = 32'(curve_exponent_reg);
            REG_THROTTLE_LIMIT: prdata = 32'(throttle_limit_reg);
            REG_STEERING_LIMIT: prdata = 32'(steering_limit_reg);
            REG_SLOW_FACTOR:    prdata = 32'(slow_factor_reg);
            default:            prdata = '0;
        endcase
    end

    tdsm_shaper #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .POW_STEPS    (POW_STEPS)
    ) u_shaper (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (start && !busy),
        .throttle        (throttle),
        .steering        (steering),
        .slow_en         (slow_en),
        .deadzone        (deadzone_reg),
        .curve_exponent  (curve_exponent_reg),
        .throttle_limit  (throttle_limit_reg),
        .steering_limit  (steering_limit_reg),
        .out_valid       (shp_valid),
        .out_slow        (shp_slow),
        .throttle_shaped (thr_shaped),
        .steering_shaped (ste_shaped)
    );

    // Mix the axes and clamp to plus or minus one
    assign sum_l = {thr_shaped[W], thr_shaped} + {ste_shaped[W], ste_shaped};
    assign sum_r = {thr_shaped[W], thr_shaped} - {ste_shaped[W], ste_shaped};

    always_comb
    begin
        mix_next[0] = (sum_l > POS_ONE) ? POS_ONE[W:0] :
                      (sum_l < NEG_ONE) ? NEG_ONE[W:0] : sum_l[W:0];
        mix_next[1] = (sum_r > POS_ONE) ? POS_ONE[W:0] :
                      (sum_r < NEG_ONE) ? NEG_ONE[W:0] : sum_r[W:0];
    end

    // Scale magnitudes in slow mode, truncating toward zero
    genvar i;
    generate
        for (i = 0; i < 2; i++)
        begin : g_side
            logic [W:0]      mag_full;
            logic [W+F-1:0]  prod;
            logic [W-1:0]    scaled;
            assign mag_full = mix_reg[i][W] ? 1'(0) - mix_reg[i] : mix_reg[i];
            assign prod     = (W+F)'(mag_full[W-1:0]) * (W+F)'(slow_factor_reg);
            assign scaled   = prod[W+F-1:F];
            assign scl_next[i] = !mix_slow_reg ? mix_reg[i] :
                                 mix_reg[i][W] ? -$signed({1'b0, scaled})
                                               : $signed({1'b0, scaled});
            assign out_next[i] = (scl_reg[i] > POS_MAX) ? POS_MAX[W-1:0] : scl_reg[i][W-1:0];
        end
    endgenerate

    // Hold payload through the final stages
    always_ff @(posedge clk)
    begin
        mix_reg      <= mix_next;
        mix_slow_reg <= shp_slow;
        scl_reg      <= scl_next;
        out_reg      <= out_next;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_vld_reg <= 1'b0;
            scl_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            mix_vld_reg <= shp_valid;
            scl_vld_reg <= mix_vld_reg;
            done_reg    <= scl_vld_reg;
        end
    end

    assign done        = done_reg;
    assign left_drive  = $signed(out_reg[0]);
    assign right_drive = $signed(out_reg[1]);

endmodule

// File: src/tdsm_checker.sv
// Port-level checker for the tank drive stick mixer, bound to the top level.
// Depends on tdsm_pkg and tank_drive_stick_mixer_core.
module tdsm_checker #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int POW_STEPS    = 16
) (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic pready
);
    import tdsm_pkg::*;

    localparam int LAT = core_latency(SAMPLE_WIDTH, POW_STEPS);

    // Never refuse a sample
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy asserted");

    // Never stall the register port
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    // Every accepted beat yields a done after the fixed latency
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("missing result beat");

    // No done without an accepted beat at the fixed latency
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("spurious result beat");

endmodule

bind tank_drive_stick_mixer_core tdsm_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .POW_STEPS    (POW_STEPS)
) u_tdsm_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .pready (pready)
);
